/* rtl/uwwlb_pkg.sv */
// ----------------------------------------------------------------------------
// uwwlb_pkg
// Shared types, codes and helpers of the UTF-8 word-wrap line breaker.
// ----------------------------------------------------------------------------
`default_nettype none

package uwwlb_pkg;

    // input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // configuration register indexes
    localparam logic REG_LINE_LIMIT = 1'b0;
    localparam logic REG_LINE_WIDTH = 1'b1;

    // configuration reset values
    localparam logic [7:0] LINE_LIMIT_RST = 8'd8;
    localparam logic [7:0] LINE_WIDTH_RST = 8'd32;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // lookahead depth and the most results one item may produce
    localparam logic [1:0] LA_FULL     = 2'd3;
    localparam logic [3:0] MAX_RESULTS = 4'd6;

    // result queue geometry
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = 2;

    typedef struct packed {
        logic        has_line;
        logic [15:0] start;
        logic [7:0]  length;
        logic [7:0]  count;
        logic        last;
    } result_t;

    // narrow line-tracking state that travels with the judge step
    typedef struct packed {
        logic [7:0] line_bytes;
        logic       blank_valid;
        logic [7:0] lines;
        logic       prior_nl;
        logic [1:0] skip;
    } judge_ctl_t;

    typedef struct packed {
        logic [2:0] level;
        logic       room;
        logic       nonempty;
    } outq_stat_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    // length in bytes of the unit that starts with b0
    function automatic logic [2:0] unit_len(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        logic [2:0] len;
        len = 3'd1;
        if ((b0 & 8'h80) == 8'h00)
            len = 3'd1;
        else if ((b0 & 8'hE0) == 8'hC0 && is_cont(b1))
            len = 3'd2;
        else if ((b0 & 8'hF0) == 8'hE0 && is_cont(b1) && is_cont(b2))
            len = 3'd3;
        else if ((b0 & 8'hF8) == 8'hF0 && is_cont(b1) && is_cont(b2) && is_cont(b3))
            len = 3'd4;
        return len;
    endfunction

endpackage

`default_nettype wire

/* rtl/utf8_word_wrap_line_breaker.sv */
// ----------------------------------------------------------------------------
// utf8_word_wrap_line_breaker
// Greedy word wrap over a UTF-8 byte stream, giving line descriptors.
// ----------------------------------------------------------------------------
// Text bytes enter on the item channel one per cycle; each transaction
// yields one or more results on the res channel, the final one with last
// set, and a transaction that closes no line yields one result with
// has_line low. A byte is taken every cycle while results drain as fast as
// they come; item_ready drops whenever the four-entry result queue holds
// more than two results. A byte whose wrap step closes two lines puts two
// results into the queue. The end marker judges each byte still in the
// three-byte lookahead, the first at its own acceptance, then emits the
// closing line; item_ready stays low until that final step, and each flush
// step waits for queue room. The wrap step unit judges one byte per cycle
// when the queue has room; the queue drains one result per cycle on res_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_word_wrap_line_breaker
    import uwwlb_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic        op,
    input  wire logic [7:0]  text_byte,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             has_line,
    output logic      [15:0] seg_start,
    output logic      [7:0]  seg_length,
    output logic      [7:0]  seg_count,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // configuration
    logic [7:0] line_limit_reg;
    logic [7:0] line_width_reg;

    // text state
    logic [7:0]               la_reg [3];
    logic [7:0]               la_next [3];
    logic [1:0]               la_cnt_reg;
    logic [1:0]               la_cnt_next;
    logic [POSITION_BITS-1:0] byte_pos_reg;
    logic [POSITION_BITS-1:0] byte_pos_next;
    logic [POSITION_BITS-1:0] open_start_reg;
    logic [POSITION_BITS-1:0] open_start_next;
    logic [POSITION_BITS-1:0] blank_pos_reg;
    logic [POSITION_BITS-1:0] blank_pos_next;
    judge_ctl_t               ctl_reg;
    judge_ctl_t               ctl_next;

    // transaction sequencing
    logic       flush_reg;
    logic       flush_next;
    result_t    pend_reg;
    result_t    pend_next;
    logic       pend_valid_reg;
    logic       pend_valid_next;
    logic [3:0] item_lines_reg;
    logic [3:0] item_lines_next;

    // judge unit
    logic [7:0]               judge_n3;
    logic [POSITION_BITS-1:0] j_byte_pos;
    logic [POSITION_BITS-1:0] j_open_start;
    logic [POSITION_BITS-1:0] j_blank_pos;
    judge_ctl_t               j_ctl;
    result_t                  j_line_a;
    result_t                  j_line_b;

    // step control
    logic       item_fire;
    logic       text_step;
    logic       flush_step;
    logic       do_fill;
    logic       do_judge;
    logic       do_final;
    logic       item_end;
    logic       step_go;
    result_t    fin_line;
    result_t    line_a;
    result_t    line_b;
    result_t    filler;
    logic       a_keep;
    logic       b_keep;
    result_t    cand [3];
    logic [2:0] cand_v;
    result_t    list [3];
    logic [1:0] k;

    // result queue
    logic [1:0] push_cnt;
    result_t    push_data [2];
    logic       pop;
    result_t    q_head;
    outq_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= LINE_LIMIT_RST;
            line_width_reg <= LINE_WIDTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINE_LIMIT: line_limit_reg <= cfg_data;
                REG_LINE_WIDTH: line_width_reg <= cfg_data;
            endcase
        end
    end

    assign item_ready = !flush_reg && q_stat.room;
    assign item_fire  = item_valid && item_ready;
    assign text_step  = item_fire && (op == OP_BYTE);
    assign flush_step = flush_reg ? q_stat.room : (item_fire && (op == OP_END));
    assign do_fill    = text_step && (la_cnt_reg != LA_FULL);
    assign do_judge   = (text_step && (la_cnt_reg == LA_FULL))
                        || (flush_step && (la_cnt_reg != 2'd0));
    assign do_final   = flush_step && (la_cnt_reg == 2'd0);
    assign item_end   = text_step || do_final;
    assign step_go    = text_step || flush_step;
    // past the end of the text the lookahead reads zero
    assign judge_n3   = text_step ? text_byte : 8'h00;

    uwwlb_judge #(
        .POSITION_BITS(POSITION_BITS)
    ) u_judge (
        .cur_byte        (la_reg[0]),
        .next1           (la_reg[1]),
        .next2           (la_reg[2]),
        .next3           (judge_n3),
        .line_limit      (line_limit_reg),
        .line_width      (line_width_reg),
        .byte_pos        (byte_pos_reg),
        .open_start      (open_start_reg),
        .blank_pos       (blank_pos_reg),
        .ctl             (ctl_reg),
        .byte_pos_next   (j_byte_pos),
        .open_start_next (j_open_start),
        .blank_pos_next  (j_blank_pos),
        .ctl_next        (j_ctl),
        .line_a          (j_line_a),
        .line_b          (j_line_b)
    );

    // closing line at the end marker
    always_comb
    begin
        fin_line          = '0;
        fin_line.has_line = (ctl_reg.lines < line_limit_reg)
                            && (ctl_reg.line_bytes != 8'd0 || ctl_reg.lines == 8'd0
                                || ctl_reg.prior_nl);
        fin_line.start    = 16'(open_start_reg);
        fin_line.length   = ctl_reg.line_bytes;
        fin_line.count    = ctl_reg.lines + 8'd1;
    end

    // text state update
    always_comb
    begin
        la_next         = la_reg;
        la_cnt_next     = la_cnt_reg;
        byte_pos_next   = byte_pos_reg;
        open_start_next = open_start_reg;
        blank_pos_next  = blank_pos_reg;
        ctl_next        = ctl_reg;

        if (do_fill)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (la_cnt_reg == 2'(i))
                    la_next[i] = text_byte;
            end
            la_cnt_next = la_cnt_reg + 2'd1;
        end

        if (do_judge)
        begin
            la_next[0]      = la_reg[1];
            la_next[1]      = la_reg[2];
            la_next[2]      = judge_n3;
            byte_pos_next   = j_byte_pos;
            open_start_next = j_open_start;
            blank_pos_next  = j_blank_pos;
            ctl_next        = j_ctl;
            if (!text_step)
                la_cnt_next = la_cnt_reg - 2'd1;
        end

        if (do_final)
        begin
            la_next         = '{default: 8'h00};
            la_cnt_next     = 2'd0;
            byte_pos_next   = '0;
            open_start_next = '0;
            blank_pos_next  = '0;
            ctl_next        = '0;
        end
    end

    // gather the lines of this step and queue them in order
    always_comb
    begin
        line_a = do_judge ? j_line_a : (do_final ? fin_line : result_t'('0));
        line_b = do_judge ? j_line_b : result_t'('0);

        filler          = '0;
        filler.count    = ctl_next.lines;
        filler.last     = 1'b1;

        // drop lines beyond the per-transaction result limit
        a_keep = line_a.has_line && (item_lines_reg + 4'd1 <= MAX_RESULTS);
        b_keep = line_b.has_line && (item_lines_reg + 4'd2 <= MAX_RESULTS);

        cand[0] = pend_reg;
        cand[1] = line_a;
        cand[2] = line_b;
        cand_v  = {b_keep, a_keep, pend_valid_reg};

        list = '{default: result_t'('0)};
        k    = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (cand_v[i])
            begin
                list[k] = cand[i];
                k       = k + 2'd1;
            end
        end

        push_cnt        = 2'd0;
        push_data[0]    = list[0];
        push_data[1]    = list[1];
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        item_lines_next = item_lines_reg;

        if (step_go)
        begin
            if (item_end)
            begin
                pend_valid_next = 1'b0;
                item_lines_next = 4'd0;
                if (k == 2'd0)
                begin
                    push_data[0] = filler;
                    push_cnt     = 2'd1;
                end
                else
                begin
                    push_cnt = k;
                    if (k == 2'd1)
                        push_data[0].last = 1'b1;
                    else
                        push_data[1].last = 1'b1;
                end
            end
            else
            begin
                item_lines_next = item_lines_reg + {3'd0, line_a.has_line}
                                  + {3'd0, line_b.has_line};
                // hold back the newest line until we know whether it is the last
                if (k != 2'd0)
                begin
                    pend_next       = list[k - 2'd1];
                    pend_valid_next = 1'b1;
                    push_cnt        = k - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg         <= '{default: 8'h00};
            la_cnt_reg     <= 2'd0;
            byte_pos_reg   <= '0;
            open_start_reg <= '0;
            blank_pos_reg  <= '0;
            ctl_reg        <= '0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            item_lines_reg <= 4'd0;
        end
        else
        begin
            la_reg         <= la_next;
            la_cnt_reg     <= la_cnt_next;
            byte_pos_reg   <= byte_pos_next;
            open_start_reg <= open_start_next;
            blank_pos_reg  <= blank_pos_next;
            ctl_reg        <= ctl_next;
            flush_reg      <= flush_next;
            pend_valid_reg <= pend_valid_next;
            item_lines_reg <= item_lines_next;
        end
    end

    assign flush_next = flush_step ? !do_final : flush_reg;

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign pop = res_valid && res_ready;

    uwwlb_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    assign res_valid  = q_stat.nonempty;
    assign has_line   = q_head.has_line;
    assign seg_start  = q_head.start;
    assign seg_length = q_head.length;
    assign seg_count  = q_head.count;
    assign last       = q_head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= 3'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_filler_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_line |-> last)
        else $error("result without a line is not the last one");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        do_final |=> la_cnt_reg == 2'd0 && byte_pos_reg == '0 && ctl_reg == '0
                     && !flush_reg)
        else $error("text state not cleared after end marker");

    a_pend_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> flush_reg)
        else $error("held-back line outside an end marker sequence");

endmodule

`default_nettype wire

/* rtl/uwwlb_judge.sv */
// ----------------------------------------------------------------------------
// uwwlb_judge
// One wrap step for one text byte: unit length, newline, blank and
// overflow breaks. Gives the next line state and up to two line records.
// ----------------------------------------------------------------------------
`default_nettype none

module uwwlb_judge
    import uwwlb_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  wire logic [7:0]               cur_byte,
    input  wire logic [7:0]               next1,
    input  wire logic [7:0]               next2,
    input  wire logic [7:0]               next3,
    input  wire logic [7:0]               line_limit,
    input  wire logic [7:0]               line_width,
    input  wire logic [POSITION_BITS-1:0] byte_pos,
    input  wire logic [POSITION_BITS-1:0] open_start,
    input  wire logic [POSITION_BITS-1:0] blank_pos,
    input  wire judge_ctl_t               ctl,
    output logic      [POSITION_BITS-1:0] byte_pos_next,
    output logic      [POSITION_BITS-1:0] open_start_next,
    output logic      [POSITION_BITS-1:0] blank_pos_next,
    output judge_ctl_t                    ctl_next,
    output result_t                       line_a,
    output result_t                       line_b
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] st;
    logic [POSITION_BITS-1:0] bp;
    logic [7:0]               by;
    logic [7:0]               ln;
    logic [7:0]               head;
    logic                     bv;
    logic                     stop;
    logic [1:0]               sk;
    logic [2:0]               seq;
    logic                     blank;

    assign pos_inc = byte_pos + POS_ONE;

    always_comb
    begin
        st     = open_start;
        bp     = blank_pos;
        by     = ctl.line_bytes;
        ln     = ctl.lines;
        bv     = ctl.blank_valid;
        sk     = ctl.skip;
        stop   = 1'b0;
        head   = 8'd0;
        seq    = unit_len(cur_byte, next1, next2, next3);
        blank  = (cur_byte == CH_SPACE) || (cur_byte == CH_TAB);
        line_a = '0;
        line_b = '0;

        if (ctl.skip != 2'd0)
        begin
            sk = ctl.skip - 2'd1;
        end
        else if (ln >= line_limit)
        begin
            stop = 1'b1;
        end
        else if (cur_byte == CH_NL)
        begin
            line_a.has_line = 1'b1;
            line_a.start    = 16'(st);
            line_a.length   = by;
            line_a.count    = ln + 8'd1;
            ln = ln + 8'd1;
            st = pos_inc;
            by = 8'd0;
            bv = 1'b0;
        end
        else
        begin
            // first overflow: break at the last blank, or force
            if (by != 8'd0 && ({1'b0, by} + {6'd0, seq}) > {1'b0, line_width})
            begin
                line_a.has_line = 1'b1;
                line_a.start    = 16'(st);
                line_a.count    = ln + 8'd1;
                if (bv)
                begin
                    head          = 8'(bp - st);
                    line_a.length = head;
                    by            = by - head - 8'd1;
                    st            = bp + POS_ONE;
                end
                else
                begin
                    line_a.length = by;
                    st            = byte_pos;
                    by            = 8'd0;
                end
                bv = 1'b0;
                ln = ln + 8'd1;
                if (ln >= line_limit)
                    stop = 1'b1;
                // the tail after the blank may still not fit: force
                if (!stop && by != 8'd0 && ({1'b0, by} + {6'd0, seq}) > {1'b0, line_width})
                begin
                    line_b.has_line = 1'b1;
                    line_b.start    = 16'(st);
                    line_b.length   = by;
                    line_b.count    = ln + 8'd1;
                    st = byte_pos;
                    by = 8'd0;
                    ln = ln + 8'd1;
                    if (ln >= line_limit)
                        stop = 1'b1;
                end
            end

            if (!stop)
            begin
                if (blank && by == 8'd0)
                begin
                    // drop leading blank
                    st = pos_inc;
                end
                else
                begin
                    if (blank)
                    begin
                        bp = byte_pos;
                        bv = 1'b1;
                    end
                    by = by + {5'd0, seq};
                    sk = 2'(seq - 3'd1);
                end
            end
        end

        byte_pos_next        = pos_inc;
        open_start_next      = st;
        blank_pos_next       = bp;
        ctl_next.line_bytes  = by;
        ctl_next.blank_valid = bv;
        ctl_next.lines       = ln;
        ctl_next.prior_nl    = (cur_byte == CH_NL);
        ctl_next.skip        = sk;
    end

endmodule

`default_nettype wire

/* rtl/uwwlb_outq.sv */
// ----------------------------------------------------------------------------
// uwwlb_outq
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module uwwlb_outq
    import uwwlb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire result_t    push_data [2],
    input  wire logic       pop,
    output result_t         head,
    output outq_stat_t      stat
);

    result_t                  entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_next;
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_plus1;
    logic [OUTQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [OUTQ_PTR_BITS-1:0] rd_ptr_next;
    logic [2:0]               level_reg;
    logic [2:0]               level_next;

    assign wr_ptr_plus1 = wr_ptr_reg + OUTQ_PTR_BITS'(1);
    assign wr_ptr_next  = wr_ptr_reg + OUTQ_PTR_BITS'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + OUTQ_PTR_BITS'(pop);
    assign level_next   = level_reg + {1'b0, push_cnt} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= push_data[0];
        if (push_cnt == 2'd2)
            entry_reg[wr_ptr_plus1] <= push_data[1];
    end

    assign head          = entry_reg[rd_ptr_reg];
    assign stat.level    = level_reg;
    assign stat.room     = level_reg <= 3'(OUTQ_DEPTH - 2);
    assign stat.nonempty = level_reg != 3'd0;

endmodule

`default_nettype wire

/* verif/utf8_word_wrap_line_breaker_tb.sv */
// ----------------------------------------------------------------------------
// utf8_word_wrap_line_breaker_tb
// Self-checking bench for the UTF-8 greedy word-wrap line breaker.
// ----------------------------------------------------------------------------
// A short table of hand-picked texts goes in first. Random texts follow under
// a series of width and line-limit settings: mostly words of ASCII and UTF-8
// units split by blanks and newlines, with some raw byte noise. A line
// predictor inside the bench tracks every accepted transaction and each
// result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_word_wrap_line_breaker_tb;

    import uwwlb_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        bit         typed;
        result_t    want;
    } text_row_t;

    localparam result_t NO_LINE    = '{1'b0, 16'd0, 8'd0, 8'd0, 1'b1};
    localparam result_t EMPTY_LINE = '{1'b1, 16'd0, 8'd0, 8'd1, 1'b1};
    localparam int      NUM_PHASES = 9;
    localparam int      PHASE_ITEMS = 32;
    localparam int      HOLD_CYCLES = 120;
    localparam int      TEXT_CAP    = 48;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic       op;
    logic [7:0] text_byte;
    logic       res_valid;
    logic       res_ready;
    logic       has_line;
    logic [15:0] seg_start;
    logic [7:0] seg_length;
    logic [7:0] seg_count;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // directed texts: empty, byte then newline, mixed units, leading blanks
    text_row_t directed_rows [26] = '{
        '{OP_END,  8'h00, 1'b1, EMPTY_LINE},
        '{OP_BYTE, 8'h61, 1'b1, NO_LINE},
        '{OP_BYTE, 8'h0A, 1'b1, NO_LINE},
        '{OP_END,  8'hFF, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h00, 1'b1, NO_LINE},
        '{OP_BYTE, 8'hC3, 1'b1, NO_LINE},
        '{OP_BYTE, 8'hA9, 1'b1, NO_LINE},
        '{OP_BYTE, 8'h20, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hE2, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h82, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hAC, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h09, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hF0, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h9F, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h98, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h80, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h80, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hFF, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hC3, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h41, 1'b0, NO_LINE},
        '{OP_BYTE, 8'hF0, 1'b0, NO_LINE},
        '{OP_END,  8'h5A, 1'b0, NO_LINE},
        '{OP_BYTE, 8'h20, 1'b1, NO_LINE},
        '{OP_BYTE, 8'h09, 1'b1, NO_LINE},
        '{OP_BYTE, 8'h41, 1'b1, NO_LINE},
        '{OP_END,  8'hA5, 1'b0, NO_LINE}
    };

    int phase_limits [NUM_PHASES] = '{1, 255, 3, 2, 255, 1, 0, 0, 6};
    int phase_widths [NUM_PHASES] = '{1, 255, 8, 1, 4, 255, 0, 0, 12};

    // predictor state
    logic [7:0]  cfg_limit;
    logic [7:0]  cfg_width;
    logic [7:0]  la_buf [3];
    logic [1:0]  la_fill;
    logic [15:0] text_pos;
    logic [15:0] open_start;
    logic [7:0]  open_bytes;
    logic [15:0] blank_at;
    logic        blank_seen;
    logic [7:0]  lines_out;
    logic        saw_newline;
    logic [1:0]  cont_left;

    result_t step_lines [$];
    result_t lines_expected [$];

    bit      row_typed;
    result_t row_want;
    bit      hold_req;
    int      burst_left;
    int      items_sent;
    int      mismatches;

    utf8_word_wrap_line_breaker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .text_byte  (text_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .has_line   (has_line),
        .seg_start  (seg_start),
        .seg_length (seg_length),
        .seg_count  (seg_count),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // line predictor
    // ------------------------------------------------------------------
    function automatic void clear_text();
        la_buf      = '{default: 8'd0};
        la_fill     = 2'd0;
        text_pos    = 16'd0;
        open_start  = 16'd0;
        open_bytes  = 8'd0;
        blank_at    = 16'd0;
        blank_seen  = 1'b0;
        lines_out   = 8'd0;
        saw_newline = 1'b0;
        cont_left   = 2'd0;
    endfunction

    function automatic void emit_line(input logic [15:0] s, input logic [7:0] len);
        result_t r;
        lines_out = lines_out + 8'd1;
        r.has_line = 1'b1;
        r.start    = s;
        r.length   = len;
        r.count    = lines_out;
        r.last     = 1'b0;
        if (step_lines.size() < int'(MAX_RESULTS))
            step_lines.push_back(r);
    endfunction

    function automatic void judge_byte(input logic [7:0] b, input logic [7:0] n1,
                                       input logic [7:0] n2, input logic [7:0] n3);
        logic [15:0] here;
        logic [15:0] head_len;
        int          seq;
        here = text_pos;
        text_pos = text_pos + 16'd1;
        saw_newline = (b == CH_NL);
        if (cont_left != 2'd0)
        begin
            cont_left = cont_left - 2'd1;
            return;
        end
        if (lines_out >= cfg_limit)
            return;
        if (b == CH_NL)
        begin
            emit_line(open_start, open_bytes);
            open_start = here + 16'd1;
            open_bytes = 8'd0;
            blank_seen = 1'b0;
            return;
        end
        seq = 1;
        if (b[7] == 1'b0)
            seq = 1;
        else if (b[7:5] == 3'b110 && n1[7:6] == 2'b10)
            seq = 2;
        else if (b[7:4] == 4'b1110 && n1[7:6] == 2'b10 && n2[7:6] == 2'b10)
            seq = 3;
        else if (b[7:3] == 5'b11110 && n1[7:6] == 2'b10 && n2[7:6] == 2'b10
                 && n3[7:6] == 2'b10)
            seq = 4;
        while (open_bytes != 8'd0 && int'(open_bytes) + seq > int'(cfg_width))
        begin
            if (blank_seen)
            begin
                // break at the last blank; bytes after it carry over
                head_len = blank_at - open_start;
                emit_line(open_start, head_len[7:0]);
                open_bytes = open_bytes - head_len[7:0] - 8'd1;
                open_start = blank_at + 16'd1;
            end
            else
            begin
                emit_line(open_start, open_bytes);
                open_start = here;
                open_bytes = 8'd0;
            end
            blank_seen = 1'b0;
            if (lines_out >= cfg_limit)
                return;
        end
        if (b == CH_SPACE || b == CH_TAB)
        begin
            if (open_bytes == 8'd0)
            begin
                open_start = here + 16'd1;
                return;
            end
            blank_at = here;
            blank_seen = 1'b1;
        end
        open_bytes = open_bytes + 8'(seq);
        cont_left = 2'(seq - 1);
    endfunction

    function automatic void wrap_step(input logic op_i, input logic [7:0] b,
                                      input bit typed, input result_t want);
        logic [7:0] tail [6];
        int         n;
        step_lines = {};
        if (op_i == OP_BYTE)
        begin
            if (la_fill < LA_FULL)
            begin
                la_buf[la_fill] = b;
                la_fill = la_fill + 2'd1;
            end
            else
            begin
                judge_byte(la_buf[0], la_buf[1], la_buf[2], b);
                la_buf[0] = la_buf[1];
                la_buf[1] = la_buf[2];
                la_buf[2] = b;
            end
        end
        else
        begin
            // flush the lookahead with zeros past the end of the text
            tail = '{default: 8'd0};
            n = int'(la_fill);
            for (int i = 0; i < n; i++)
                tail[i] = la_buf[i];
            for (int i = 0; i < n; i++)
                judge_byte(tail[i], tail[i + 1], tail[i + 2], tail[i + 3]);
            if (lines_out < cfg_limit
                && (open_bytes != 8'd0 || lines_out == 8'd0 || saw_newline))
                emit_line(open_start, open_bytes);
            clear_text();
        end
        if (step_lines.size() == 0)
            step_lines.push_back('{1'b0, 16'd0, 8'd0, lines_out, 1'b1});
        else
            step_lines[step_lines.size() - 1].last = 1'b1;
        if (typed)
            lines_expected.push_back(want);
        else
            foreach (step_lines[i])
                lines_expected.push_back(step_lines[i]);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : track_blk
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LINE_LIMIT)
                    cfg_limit = cfg_data;
                else
                    cfg_width = cfg_data;
            end
            if (item_valid && item_ready)
                wrap_step(op, text_byte, row_typed, row_want);
            if (res_valid && res_ready)
            begin
                if (lines_expected.size() == 0)
                    report_mismatch("result with nothing pending", 0, 0);
                else
                begin
                    want = lines_expected.pop_front();
                    if (has_line !== want.has_line)
                        report_mismatch("has_line", has_line, want.has_line);
                    if (seg_start !== want.start)
                        report_mismatch("seg_start", seg_start, want.start);
                    if (seg_length !== want.length)
                        report_mismatch("seg_length", seg_length, want.length);
                    if (seg_count !== want.count)
                        report_mismatch("seg_count", seg_count, want.count);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: stall patterns and the long hold-off
    // ------------------------------------------------------------------
    initial
    begin : rx_blk
        int         mode;
        int         mode_left;
        logic [7:0] pattern;
        mode = 0;
        mode_left = 0;
        pattern = 8'hA5;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                    pattern = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= ($urandom_range(0, 9) < 6);
                    2:
                    begin
                        pattern = {pattern[6:0], pattern[7]};
                        res_ready <= pattern[0];
                    end
                    default: res_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // item and register side
    // ------------------------------------------------------------------
    task automatic send_item(input logic op_i, input logic [7:0] byte_i,
                             input bit typed, input result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        op         <= op_i;
        text_byte  <= byte_i;
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge clk); while (!item_ready);
        items_sent++;
    endtask

    // drop valid and hold until every pending result has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (lines_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_cont(ref logic [7:0] txt [$]);
        txt.push_back({2'b10, 6'($urandom)});
    endtask

    task automatic send_text(input int max_len, input bit noisy);
        logic [7:0] txt [$];
        int         target;
        int         wlen;
        int         kind;
        target = $urandom_range(0, max_len);
        while (txt.size() < target)
        begin
            if (noisy)
                txt.push_back(8'($urandom));
            else
            begin
                wlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len)
                                                   : $urandom_range(1, 8);
                repeat (wlen)
                begin
                    kind = $urandom_range(0, 19);
                    if (kind < 13)
                        txt.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    else if (kind < 15)
                    begin
                        txt.push_back({3'b110, 5'($urandom)});
                        push_cont(txt);
                    end
                    else if (kind < 17)
                    begin
                        txt.push_back({4'b1110, 4'($urandom)});
                        push_cont(txt);
                        push_cont(txt);
                    end
                    else if (kind < 19)
                    begin
                        txt.push_back({5'b11110, 3'($urandom)});
                        push_cont(txt);
                        push_cont(txt);
                        push_cont(txt);
                    end
                    else
                    begin
                        // broken unit: stray continuation or a short sequence
                        case ($urandom_range(0, 2))
                            0: push_cont(txt);
                            1: txt.push_back({3'b110, 5'($urandom)});
                            default:
                            begin
                                txt.push_back({4'b1110, 4'($urandom)});
                                push_cont(txt);
                            end
                        endcase
                        txt.push_back(8'($urandom_range(8'h41, 8'h5A)));
                    end
                end
                kind = $urandom_range(0, 9);
                if (kind < 5)
                    txt.push_back(CH_SPACE);
                else if (kind < 7)
                    txt.push_back(CH_TAB);
                else if (kind == 7)
                    txt.push_back(CH_NL);
                else if (kind == 8)
                begin
                    txt.push_back(CH_SPACE);
                    txt.push_back(CH_SPACE);
                end
                else
                begin
                    txt.push_back(CH_NL);
                    txt.push_back(CH_SPACE);
                end
            end
        end
        // trim to the drawn length; a cut unit is just a malformed tail
        while (txt.size() > target)
            void'(txt.pop_back());
        foreach (txt[i])
            send_item(OP_BYTE, txt[i], 1'b0, NO_LINE);
        send_item(OP_END, 8'($urandom), 1'b0, NO_LINE);
    endtask

    initial
    begin : main_blk
        int         max_len;
        int         phase_start;
        logic [7:0] lim;
        logic [7:0] wid;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        op         = OP_BYTE;
        text_byte  = 8'd0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_LINE_LIMIT;
        cfg_data   = 8'd0;
        row_typed  = 1'b0;
        row_want   = NO_LINE;
        hold_req   = 1'b0;
        burst_left = 0;
        items_sent = 0;
        mismatches = 0;
        cfg_limit  = LINE_LIMIT_RST;
        cfg_width  = LINE_WIDTH_RST;
        clear_text();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].b,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            lim = (phase_limits[p] == 0) ? 8'($urandom_range(1, 255))
                                         : 8'(phase_limits[p]);
            wid = (phase_widths[p] == 0) ? 8'($urandom_range(1, 255))
                                         : 8'(phase_widths[p]);
            write_reg(REG_LINE_LIMIT, lim);
            write_reg(REG_LINE_WIDTH, wid);
            max_len = 2 * int'(wid) + 6;
            if (max_len > TEXT_CAP)
                max_len = TEXT_CAP;
            // stall the result side for a long stretch while items keep coming
            if (p == 2 || p == 6)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_text(max_len, $urandom_range(0, 99) < 15);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/uwwlb_pkg.sv
rtl/uwwlb_judge.sv
rtl/uwwlb_outq.sv
rtl/utf8_word_wrap_line_breaker.sv
verif/utf8_word_wrap_line_breaker_tb.sv
